// ----- design/skhc_pkg.sv -----
package skhc_pkg;

  localparam int HashSlots  = 8192;
  localparam int MaxEntries = 4096;
  localparam int MaxKey     = 64;

  localparam int IdxW = 12;
  localparam int CntW = 32;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_COUNT  = 1'b1;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- design/skhc_if.sv -----
interface skhc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] key_byte;
  logic       last_byte;
  modport source (output valid, req_type, key_byte, last_byte, input ready);
  modport sink   (input valid, req_type, key_byte, last_byte, output ready);
endinterface

interface skhc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] entry_index;
  logic [31:0] key_count;
  modport source (output valid, status, entry_index, key_count, input ready);
  modport sink   (input valid, status, entry_index, key_count, output ready);
endinterface

// ----- design/skhc_front.sv -----
module skhc_front #(
  parameter int MAX_KEY = skhc_pkg::MaxKey,
  parameter int SLOT_W  = $clog2(skhc_pkg::HashSlots),
  parameter int KEY_W   = $clog2(MAX_KEY),
  parameter int LEN_W   = $clog2(MAX_KEY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  skhc_in_if.sink           in_ch,
  input  logic              back_idle,
  output logic              buf_we,
  output logic [KEY_W-1:0]  buf_waddr,
  output logic [7:0]        buf_wdata,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output logic              cmd_req,
  output logic [SLOT_W-1:0] cmd_hash,
  output logic [LEN_W-1:0]  cmd_len
);

  logic [LEN_W-1:0]  key_length;
  logic [SLOT_W-1:0] hash;
  logic [7:0]        lb;
  logic              keep;
  logic [SLOT_W-1:0] hash_next;
  logic              fire;

  assign lb   = skhc_pkg::to_lower(in_ch.key_byte);
  assign keep = key_length < LEN_W'(MAX_KEY);
  assign hash_next = SLOT_W'((hash << 8) + hash + SLOT_W'({{(SLOT_W){lb[7]}}, lb}));
  assign in_ch.ready = !cmd_valid && back_idle;
  assign fire        = in_ch.valid && in_ch.ready;
  assign buf_we      = fire && keep;
  assign buf_waddr   = key_length[KEY_W-1:0];
  assign buf_wdata   = lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      hash       <= SLOT_W'(1);
      cmd_valid  <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        cmd_valid <= 1'b0;
      end
      if (fire) begin
        if (in_ch.last_byte) begin
          cmd_valid  <= 1'b1;
          cmd_req    <= in_ch.req_type;
          cmd_hash   <= keep ? hash_next : hash;
          cmd_len    <= keep ? key_length + LEN_W'(1) : key_length;
          key_length <= '0;
          hash       <= SLOT_W'(1);
        end else if (keep) begin
          key_length <= key_length + LEN_W'(1);
          hash       <= hash_next;
        end
      end
    end
  end

endmodule

// ----- design/skhc_back.sv -----
module skhc_back #(
  parameter int HASH_SLOTS  = skhc_pkg::HashSlots,
  parameter int MAX_ENTRIES = skhc_pkg::MaxEntries,
  parameter int MAX_KEY     = skhc_pkg::MaxKey,
  parameter int SLOT_W      = $clog2(HASH_SLOTS),
  parameter int ENT_W       = $clog2(MAX_ENTRIES),
  parameter int KEY_W       = $clog2(MAX_KEY),
  parameter int LEN_W       = $clog2(MAX_KEY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              buf_we,
  input  logic [KEY_W-1:0]  buf_waddr,
  input  logic [7:0]        buf_wdata,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  output logic              back_idle,
  input  logic              cmd_req,
  input  logic [SLOT_W-1:0] cmd_hash,
  input  logic [LEN_W-1:0]  cmd_len,
  skhc_out_if.source        out_ch
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SLOT  = 9'b000000100,
    S_SLOTW = 9'b000001000,
    S_LEN   = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_CNT   = 9'b001000000,
    S_COPY  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  logic [7:0]       key_buffer [MAX_KEY];
  logic [7:0]       stored_keys [MAX_ENTRIES << KEY_W];
  logic [LEN_W-1:0] stored_lengths [MAX_ENTRIES];
  logic [31:0]      entry_counts [MAX_ENTRIES];
  logic [ENT_W:0]   slot_table [HASH_SLOTS];

  logic [SLOT_W-1:0] pos;
  logic [SLOT_W:0]   probes;
  logic [ENT_W:0]    entries_used;
  logic [ENT_W-1:0]  entry;
  logic [LEN_W-1:0]  cidx;
  logic              req;
  logic [LEN_W-1:0]  len;
  logic [ENT_W:0]    slot_q;
  logic [LEN_W-1:0]  slen_q;
  logic [7:0]        skey_q;
  logic [7:0]        kbuf_q;
  logic [31:0]       cnt_q;
  logic              cmp_wait;
  logic [1:0]        status;
  logic [11:0]       oidx;
  logic [31:0]       ocnt;
  logic              ovalid;

  assign back_idle = (state == S_IDLE);
  assign cmd_ready = (state == S_IDLE) && !ovalid;
  assign out_ch.valid       = ovalid;
  assign out_ch.status      = status;
  assign out_ch.entry_index = oidx;
  assign out_ch.key_count   = ocnt;

  always_ff @(posedge clk) begin
    if (buf_we) begin
      key_buffer[buf_waddr] <= buf_wdata;
    end
    kbuf_q <= key_buffer[cidx[KEY_W-1:0]];
    skey_q <= stored_keys[{entry, cidx[KEY_W-1:0]}];
    slot_q <= slot_table[pos];
    slen_q <= stored_lengths[entry];
    cnt_q  <= entry_counts[entry];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      pos          <= '0;
      entries_used <= '0;
      ovalid       <= 1'b0;
    end else begin
      if (ovalid && out_ch.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          slot_table[pos] <= '0;
          pos <= pos + SLOT_W'(1);
          if (pos == SLOT_W'(HASH_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            req    <= cmd_req;
            len    <= cmd_len;
            pos    <= cmd_hash;
            probes <= '0;
            state  <= S_SLOT;
          end
        end
        S_SLOT: state <= S_SLOTW;
        S_SLOTW: begin
          if (slot_q == '0 || probes == (SLOT_W+1)'(HASH_SLOTS)) begin
            ocnt <= '0;
            oidx <= '0;
            if (req == skhc_pkg::REQ_LOOKUP) begin
              status <= skhc_pkg::ST_NOT_FOUND;
              ovalid <= 1'b1;
              state  <= S_IDLE;
            end else if (slot_q != '0 || entries_used >= (ENT_W+1)'(MAX_ENTRIES)) begin
              status <= skhc_pkg::ST_FULL;
              ovalid <= 1'b1;
              state  <= S_IDLE;
            end else begin
              entry    <= entries_used[ENT_W-1:0];
              cidx     <= '0;
              cmp_wait <= 1'b1;
              state    <= S_COPY;
            end
          end else begin
            entry    <= ENT_W'(slot_q - (ENT_W+1)'(1));
            cidx     <= '0;
            cmp_wait <= 1'b1;
            state    <= S_LEN;
          end
        end
        S_LEN: begin
          if (cmp_wait) begin
            cmp_wait <= 1'b0;
          end else if (slen_q != len) begin
            pos    <= pos + SLOT_W'(1);
            probes <= probes + (SLOT_W+1)'(1);
            state  <= S_SLOT;
          end else begin
            cmp_wait <= 1'b1;
            state    <= S_CMP;
          end
        end
        S_CMP: begin
          if (cmp_wait) begin
            cmp_wait <= 1'b0;
          end else if (cidx == len) begin
            cmp_wait <= 1'b1;
            state    <= S_CNT;
          end else if (skey_q != kbuf_q) begin
            pos    <= pos + SLOT_W'(1);
            probes <= probes + (SLOT_W+1)'(1);
            state  <= S_SLOT;
          end else begin
            cidx     <= cidx + LEN_W'(1);
            cmp_wait <= 1'b1;
          end
        end
        S_CNT: begin
          if (cmp_wait) begin
            cmp_wait <= 1'b0;
          end else begin
            status <= skhc_pkg::ST_FOUND;
            oidx   <= 12'(entry);
            if (req == skhc_pkg::REQ_COUNT && cnt_q != '1) begin
              entry_counts[entry] <= cnt_q + 32'd1;
              ocnt <= cnt_q + 32'd1;
            end else begin
              ocnt <= cnt_q;
            end
            ovalid <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_COPY: begin
          if (cmp_wait) begin
            cmp_wait <= 1'b0;
          end else if (cidx == len) begin
            stored_lengths[entry] <= len;
            entry_counts[entry]   <= 32'd1;
            slot_table[pos]       <= entries_used + (ENT_W+1)'(1);
            entries_used          <= entries_used + (ENT_W+1)'(1);
            status <= skhc_pkg::ST_INSERTED;
            oidx   <= 12'(entry);
            ocnt   <= 32'd1;
            ovalid <= 1'b1;
            state  <= S_IDLE;
          end else begin
            stored_keys[{entry, cidx[KEY_W-1:0]}] <= kbuf_q;
            cidx     <= cidx + LEN_W'(1);
            cmp_wait <= 1'b1;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> entries_used < (ENT_W+1)'(MAX_ENTRIES))
    else $error("insert past entry limit");
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |-> !ovalid)
    else $error("command taken with result pending");
  assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(state) != S_IDLE)
    else $error("result without operation");

endmodule

// ----- design/string_key_hash_counter.sv -----
// Word-counting hash table. Send one key byte per word, last_byte on the final one;
// each key yields one result (found, inserted, not found, table full). Byte words
// take one cycle each while the table engine is idle; once a last byte is taken the
// input holds until the engine is done with that key. For each key the engine reads
// the slot at the key's hash; an empty slot ends the search. Else it compares the
// stored length, then the stored bytes one by one, probing on at a mismatch.
// An insert copies the key bytes into a new entry. A result waiting on the output
// holds the next key's operation, not its bytes. After reset, a clearing pass over
// all HASH_SLOTS slots empties the slot table, with the input held.
module string_key_hash_counter #(
  parameter int HASH_SLOTS  = skhc_pkg::HashSlots,
  parameter int MAX_ENTRIES = skhc_pkg::MaxEntries,
  parameter int MAX_KEY     = skhc_pkg::MaxKey
) (
  input logic        clk,
  input logic        rst,
  skhc_in_if.sink    in_ch,
  skhc_out_if.source out_ch
);

  localparam int SLOT_W = $clog2(HASH_SLOTS);
  localparam int KEY_W  = $clog2(MAX_KEY);
  localparam int LEN_W  = $clog2(MAX_KEY + 1);

  logic              buf_we;
  logic [KEY_W-1:0]  buf_waddr;
  logic [7:0]        buf_wdata;
  logic              cmd_valid;
  logic              cmd_ready;
  logic              back_idle;
  logic              cmd_req;
  logic [SLOT_W-1:0] cmd_hash;
  logic [LEN_W-1:0]  cmd_len;

  skhc_front #(.MAX_KEY(MAX_KEY), .SLOT_W(SLOT_W)) u_front (
    .clk, .rst, .in_ch, .back_idle, .buf_we, .buf_waddr, .buf_wdata,
    .cmd_valid, .cmd_ready, .cmd_req, .cmd_hash, .cmd_len
  );

  skhc_back #(.HASH_SLOTS(HASH_SLOTS), .MAX_ENTRIES(MAX_ENTRIES), .MAX_KEY(MAX_KEY)) u_back (
    .clk, .rst, .buf_we, .buf_waddr, .buf_wdata,
    .cmd_valid, .cmd_ready, .back_idle, .cmd_req, .cmd_hash, .cmd_len, .out_ch
  );

endmodule
